@@ rtl/gtw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gtw_pkg;

  localparam int unsigned XW = 34;   // CORDIC x/y width, Q30 with headroom
  localparam int unsigned ZW = 36;   // CORDIC angle width, Q30 with headroom
  localparam int unsigned ArmW = 33;
  localparam logic signed [XW-1:0] CordicGain = 34'sd652032874;

  localparam logic [1:0] RegGimbal = 2'd0;
  localparam logic [1:0] RegMaxAngle = 2'd1;
  localparam logic [1:0] RegNozzle = 2'd2;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [ZW-1:0] z;
  } lane_t;

  // Per-item information that travels beside the angle lanes.
  typedef struct packed {
    logic            gimbal;
    logic [31:0]     thrust;
    logic [ArmW-1:0] arm;
  } side_t;

  function automatic logic [ZW-1:0] atan_q30(input int unsigned i);
    logic [ZW-1:0] r;
    begin
      case (i)
        0: r = 36'd843314856;
        1: r = 36'd497837829;
        2: r = 36'd263043836;
        3: r = 36'd133525158;
        4: r = 36'd67021686;
        5: r = 36'd33543515;
        6: r = 36'd16775850;
        7: r = 36'd8388437;
        8: r = 36'd4194282;
        9: r = 36'd2097149;
        10: r = 36'd1048575;
        11: r = 36'd524287;
        12: r = 36'd262143;
        13: r = 36'd131071;
        14: r = 36'd65535;
        15: r = 36'd32767;
        16: r = 36'd16383;
        17: r = 36'd8191;
        18: r = 36'd4095;
        19: r = 36'd2047;
        20: r = 36'd1023;
        21: r = 36'd511;
        22: r = 36'd255;
        23: r = 36'd127;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] sat32(input logic signed [69:0] v);
    logic [31:0] r;
    begin
      if (v > 70'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -70'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
    end
  endfunction

  function automatic logic [47:0] sat48(input logic signed [65:0] v);
    logic [47:0] r;
    begin
      if (v > 66'sd140737488355327) r = 48'h7FFF_FFFF_FFFF;
      else if (v < -66'sd140737488355328) r = 48'h8000_0000_0000;
      else r = v[47:0];
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/gtw_cordic_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gtw_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          vin,
  input  wire gtw_pkg::side_t side_in,
  input  wire gtw_pkg::lane_t pin,
  input  wire gtw_pkg::lane_t yin,
  output logic               vout,
  output gtw_pkg::side_t     side_out,
  output gtw_pkg::lane_t     pout,
  output gtw_pkg::lane_t     yout
);

  // One micro-rotation for each of the pitch and yaw lanes.
  function automatic gtw_pkg::lane_t rot(input gtw_pkg::lane_t a);
    gtw_pkg::lane_t r;
    logic signed [gtw_pkg::XW-1:0] dx;
    logic signed [gtw_pkg::XW-1:0] dy;
    begin
      dx = $signed(a.y) >>> STEP;
      dy = $signed(a.x) >>> STEP;
      if (!a.z[gtw_pkg::ZW-1]) begin
        r.x = a.x - dx;
        r.y = a.y + dy;
        r.z = a.z - gtw_pkg::atan_q30(STEP);
      end else begin
        r.x = a.x + dx;
        r.y = a.y - dy;
        r.z = a.z + gtw_pkg::atan_q30(STEP);
      end
      return r;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_out <= side_in;
      pout <= rot(pin);
      yout <= rot(yin);
    end
  end

endmodule
`default_nettype wire

@@ rtl/gtw_wrench.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gtw_wrench (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           vin,
  input  wire gtw_pkg::side_t side_in,
  input  wire gtw_pkg::lane_t pin,
  input  wire gtw_pkg::lane_t yin,
  output logic                vout,
  output logic [31:0]         force_x,
  output logic [31:0]         force_y,
  output logic [31:0]         force_z,
  output logic [47:0]         moment_y,
  output logic [47:0]         moment_z,
  output logic [47:0]         axis_effectiveness,
  output logic [1:0]          effect_count
);

  localparam logic signed [69:0] HalfQ30 = 70'sd536870912;
  localparam logic signed [65:0] HalfQ16 = 66'sd32768;

  // Stage 1: thrust times cos(pitch) and sin(pitch).
  logic v1, v2, v3;
  gtw_pkg::side_t s1, s2, s3;
  logic [33:0] tcp1, fzr1, sy1, cy1;
  logic signed [69:0] p_tcp, p_fz;

  assign p_tcp = 70'($signed(side_in.thrust)) * 70'($signed(pin.x));
  assign p_fz = 70'($signed(side_in.thrust)) * 70'($signed(pin.y));

  // Stage 2: second rotation and 32-bit saturation.
  logic signed [69:0] tcp1_w, p_fx, p_fy, r_fx, r_fy, r_fz;
  logic [31:0] fx2, fy2, fz2;

  assign tcp1_w = 70'($signed(tcp1));
  assign p_fx = tcp1_w * 70'($signed(cy1));
  assign p_fy = tcp1_w * 70'($signed(sy1));
  assign r_fx = (p_fx + HalfQ30) >>> 30;
  assign r_fy = -((p_fy + HalfQ30) >>> 30);
  assign r_fz = 70'($signed(fzr1));

  // Stage 3: arm products.
  logic signed [65:0] arm_w, pmy, pmz, pef;
  logic [65:0] my3, mz3, ef3;
  logic [31:0] fx3, fy3, fz3;

  assign arm_w = 66'($signed(s2.arm));
  assign pmy = arm_w * 66'($signed(fz2));
  assign pmz = arm_w * (-66'($signed(fy2)));
  assign pef = arm_w * 66'($signed(s2.thrust));

  logic active3;
  assign active3 = s3.gimbal && !s3.thrust[31] && (s3.thrust != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vout <= 1'b0;
    end else if (adv) begin
      v1 <= vin;
      v2 <= v1;
      v3 <= v2;
      vout <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= side_in;
      tcp1 <= 34'((p_tcp + HalfQ30) >>> 30);
      fzr1 <= 34'((p_fz + HalfQ30) >>> 30);
      sy1 <= yin.y;
      cy1 <= yin.x;

      s2 <= s1;
      fx2 <= gtw_pkg::sat32(r_fx);
      fy2 <= gtw_pkg::sat32(r_fy);
      fz2 <= gtw_pkg::sat32(r_fz);

      s3 <= s2;
      fx3 <= fx2;
      fy3 <= fy2;
      fz3 <= fz2;
      my3 <= pmy;
      mz3 <= pmz;
      ef3 <= pef;

      // Output register: rounding, saturation and the special mounts.
      if (!s3.gimbal) begin
        force_x <= s3.thrust;
        force_y <= '0;
        force_z <= '0;
        moment_y <= '0;
        moment_z <= '0;
        axis_effectiveness <= '0;
        effect_count <= 2'd0;
      end else if (!active3) begin
        force_x <= '0;
        force_y <= '0;
        force_z <= '0;
        moment_y <= '0;
        moment_z <= '0;
        axis_effectiveness <= '0;
        effect_count <= 2'd0;
      end else begin
        force_x <= fx3;
        force_y <= fy3;
        force_z <= fz3;
        moment_y <= gtw_pkg::sat48(($signed(my3) + HalfQ16) >>> 16);
        moment_z <= gtw_pkg::sat48(($signed(mz3) + HalfQ16) >>> 16);
        axis_effectiveness <= gtw_pkg::sat48(($signed(ef3) + HalfQ16) >>> 16);
        effect_count <= 2'd2;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/gimbal_thrust_wrench.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Body-frame force and moment of a gimbaled nozzle. Each input transaction
// carries thrust, pitch and yaw commands and the centre-of-gravity station, and
// yields exactly one result transaction. The block is fully pipelined: one
// transaction is accepted every cycle while in_stall is low. Each result passes
// the input register, one CORDIC stage per iteration, three multiply stages and
// the output register. The whole pipeline advances together; it holds only
// while a result sits in the output register and out_stall is high, and in_stall
// reflects exactly that. Registers are written through the configuration port
// (index 0 gimbal present, 1 maximum gimbal angle, 2 nozzle station); the user
// must write them only while the block is idle, which the block does not
// enforce. cfg_ready is always high and unknown indexes are ignored.
module gimbal_thrust_wrench #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 13
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] thrust,
  input  wire logic [15:0] pitch_command,
  input  wire logic [15:0] yaw_command,
  input  wire logic [31:0] cg_station,
  input  wire logic        cg_valid,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      force_x,
  output logic [31:0]      force_y,
  output logic [31:0]      force_z,
  output logic [47:0]      moment_y,
  output logic [47:0]      moment_z,
  output logic [47:0]      axis_effectiveness,
  output logic [1:0]       effect_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned AngShift = 30 - ANGLE_FRAC_BITS;

  // Configuration registers.
  logic        gimbal_present;
  logic [12:0] max_gimbal_angle;
  logic [31:0] nozzle_station;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gimbal_present <= 1'b1;
      max_gimbal_angle <= 13'd1430;
      nozzle_station <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gtw_pkg::RegGimbal: gimbal_present <= cfg_data[0];
        gtw_pkg::RegMaxAngle: max_gimbal_angle <= cfg_data[12:0];
        gtw_pkg::RegNozzle: nozzle_station <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a finished result is being held.
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Clamp to the symmetric gimbal limit and move to Q30.
  function automatic logic [gtw_pkg::ZW-1:0] to_z(input logic [15:0] a,
                                                  input logic [12:0] m);
    logic signed [16:0] av;
    logic signed [16:0] mv;
    logic signed [16:0] c;
    begin
      av = 17'($signed(a));
      mv = $signed({4'b0, m});
      if (av > mv) c = mv;
      else if (av < -mv) c = -mv;
      else c = av;
      return gtw_pkg::ZW'(c) << AngShift;
    end
  endfunction

  logic v0;
  gtw_pkg::side_t s0;
  gtw_pkg::lane_t p0, y0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0.gimbal <= gimbal_present;
      s0.thrust <= thrust;
      s0.arm <= cg_valid ? 33'($signed(nozzle_station)) - 33'($signed(cg_station))
                         : 33'($signed(nozzle_station));
      p0.x <= gtw_pkg::CordicGain;
      p0.y <= '0;
      p0.z <= to_z(pitch_command, max_gimbal_angle);
      y0.x <= gtw_pkg::CordicGain;
      y0.y <= '0;
      y0.z <= to_z(yaw_command, max_gimbal_angle);
    end
  end

  // CORDIC: one register stage per iteration.
  logic           cv [0:CORDIC_STEPS];
  gtw_pkg::side_t cs [0:CORDIC_STEPS];
  gtw_pkg::lane_t cp [0:CORDIC_STEPS];
  gtw_pkg::lane_t cy [0:CORDIC_STEPS];

  assign cv[0] = v0;
  assign cs[0] = s0;
  assign cp[0] = p0;
  assign cy[0] = y0;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    gtw_cordic_stage #(.STEP(g)) u_stage (
      .clk(clk), .rst(rst), .adv(adv),
      .vin(cv[g]), .side_in(cs[g]), .pin(cp[g]), .yin(cy[g]),
      .vout(cv[g+1]), .side_out(cs[g+1]), .pout(cp[g+1]), .yout(cy[g+1])
    );
  end

  gtw_wrench u_wrench (
    .clk(clk), .rst(rst), .adv(adv),
    .vin(cv[CORDIC_STEPS]), .side_in(cs[CORDIC_STEPS]),
    .pin(cp[CORDIC_STEPS]), .yin(cy[CORDIC_STEPS]),
    .vout(out_valid),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .moment_y(moment_y), .moment_z(moment_z),
    .axis_effectiveness(axis_effectiveness), .effect_count(effect_count)
  );

  // A held result keeps the input side stalled.
  a_stall_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input accepted while output held");

  // Only the two documented effectiveness counts occur.
  a_count_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (effect_count == 2'd0 || effect_count == 2'd2))
    else $error("bad effect_count");

  // Without control effectiveness there is no moment.
  a_no_moment: assert property (@(posedge clk) disable iff (rst)
    (out_valid && effect_count == 2'd0) |->
      (moment_y == '0 && moment_z == '0 && axis_effectiveness == '0))
    else $error("moment without effectiveness");

  // A stage that could not advance keeps its valid bit.
  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    (!adv && v0) |=> v0)
    else $error("input stage lost an item under stall");

endmodule
`default_nettype wire

@@ dv/gtw_wrench_checker.sv @@
`timescale 1ns / 1ps
module gtw_wrench_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [31:0] thrust,
  input wire logic [15:0] pitch_command,
  input wire logic [15:0] yaw_command,
  input wire logic [31:0] cg_station,
  input wire logic        cg_valid,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] force_x,
  input wire logic [31:0] force_y,
  input wire logic [31:0] force_z,
  input wire logic [47:0] moment_y,
  input wire logic [47:0] moment_z,
  input wire logic [47:0] axis_effectiveness,
  input wire logic [1:0]  effect_count,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [1:0]  cfg_index,
  input wire logic [31:0] cfg_data,
  output int              failures,
  output int              pending
);

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic [47:0] my;
    logic [47:0] mz;
    logic [47:0] eff;
    logic [1:0]  cnt;
  } wrench_t;

  localparam int Steps = 16;
  localparam int AngFrac = 13;

  wrench_t wrench_q[$];
  logic        gimbal_on;
  logic [12:0] angle_limit;
  logic signed [31:0] nozzle;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint q30_mul(longint a, longint c);
    return floor_shift(a * c + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint arm_mul(longint arm, longint f);
    return clip(floor_shift(arm * f + (64'sd1 <<< 15), 16), 48);
  endfunction

  // Rotation-mode CORDIC on a clamped angle, giving sine and cosine in Q30.
  function automatic void rotate(longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    longint tab[24];
    tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
            16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
            131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
    x = 652032874;
    y = 0;
    z = ang <<< (30 - AngFrac);
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= tab[i];
      end else begin
        x += dx; y -= dy; z += tab[i];
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint limit_angle(longint a);
    longint m;
    m = angle_limit;
    return a > m ? m : (a < -m ? -m : a);
  endfunction

  function automatic wrench_t predict_wrench(logic [31:0] t_raw, logic [15:0] p_raw,
                                             logic [15:0] y_raw, logic [31:0] cg_raw,
                                             logic cgv);
    wrench_t r;
    longint t, p, yw, sp, cp, sy, cy, tcp, fx, fy, fz, arm;
    longint my_v, mz_v, ef_v;
    r = '0;
    t = longint'($signed(t_raw));
    p = limit_angle(longint'($signed(p_raw)));
    yw = limit_angle(longint'($signed(y_raw)));
    if (!gimbal_on) begin
      r.fx = t_raw;
    end else if (t > 0) begin
      rotate(p, sp, cp);
      rotate(yw, sy, cy);
      tcp = q30_mul(t, cp);
      fx = clip(q30_mul(tcp, cy), 32);
      fy = clip(-q30_mul(tcp, sy), 32);
      fz = clip(q30_mul(t, sp), 32);
      arm = cgv ? longint'(nozzle) - longint'($signed(cg_raw)) : longint'(nozzle);
      my_v = arm_mul(arm, fz);
      mz_v = arm_mul(arm, -fy);
      ef_v = arm_mul(arm, t);
      r.fx = fx[31:0];
      r.fy = fy[31:0];
      r.fz = fz[31:0];
      r.my = my_v[47:0];
      r.mz = mz_v[47:0];
      r.eff = ef_v[47:0];
      r.cnt = 2'd2;
    end
    return r;
  endfunction

  assign pending = wrench_q.size();

  always @(posedge clk) begin
    wrench_t exp_w;
    wrench_t got;
    if (rst) begin
      gimbal_on <= 1'b1;
      angle_limit <= 13'd1430;
      nozzle <= '0;
      failures <= 0;
      wrench_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gtw_pkg::RegGimbal: gimbal_on <= cfg_data[0];
          gtw_pkg::RegMaxAngle: angle_limit <= cfg_data[12:0];
          gtw_pkg::RegNozzle: nozzle <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        wrench_q.push_back(predict_wrench(thrust, pitch_command, yaw_command,
                                          cg_station, cg_valid));
      if (out_valid && !out_stall) begin
        got = '{force_x, force_y, force_z, moment_y, moment_z, axis_effectiveness,
                effect_count};
        if (wrench_q.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, got);
          failures <= failures + 1;
        end else begin
          exp_w = wrench_q.pop_front();
          if (exp_w.fx !== got.fx) $display("%0t: force_x exp %h got %h", $time, exp_w.fx, got.fx);
          if (exp_w.fy !== got.fy) $display("%0t: force_y exp %h got %h", $time, exp_w.fy, got.fy);
          if (exp_w.fz !== got.fz) $display("%0t: force_z exp %h got %h", $time, exp_w.fz, got.fz);
          if (exp_w.my !== got.my) $display("%0t: moment_y exp %h got %h", $time, exp_w.my, got.my);
          if (exp_w.mz !== got.mz) $display("%0t: moment_z exp %h got %h", $time, exp_w.mz, got.mz);
          if (exp_w.eff !== got.eff)
            $display("%0t: axis_effectiveness exp %h got %h", $time, exp_w.eff, got.eff);
          if (exp_w.cnt !== got.cnt)
            $display("%0t: effect_count exp %h got %h", $time, exp_w.cnt, got.cnt);
          if (exp_w !== got) failures <= failures + 1;
        end
      end
    end
  end
endmodule

@@ dv/tb_gimbal_thrust_wrench.sv @@
`timescale 1ns / 1ps
module tb_gimbal_thrust_wrench;

  localparam int Latency = 21;
  localparam int WatchdogLimit = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] thrust = '0;
  logic [15:0] pitch_command = '0;
  logic [15:0] yaw_command = '0;
  logic [31:0] cg_station = '0;
  logic cg_valid = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] force_x, force_y, force_z;
  logic [47:0] moment_y, moment_z, axis_effectiveness;
  logic [1:0] effect_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int failures;
  int pending;
  int quiet_cycles = 0;
  bit calm = 1'b0;          // when set, neither side idles

  always #5 clk = ~clk;

  gimbal_thrust_wrench DUT (.*);
  gtw_wrench_checker checker_i (.*);

  // The receiver stalls about 13 percent of the time, except during the calm stretch.
  always @(negedge clk)
    out_stall <= !calm && ($urandom_range(99) < 13);

  // The watchdog counts cycles in which no result completes while an input is stalled or results are pending.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || in_valid == 1'b0)
      quiet_cycles <= (in_valid && in_stall) || (pending != 0 && !(out_valid && !out_stall))
                      ? quiet_cycles + 1 : 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("gimbal_thrust_wrench test failed");
      $finish;
    end
  end

  // Sends one input transaction, with a random gap before it outside the calm stretch, and waits for acceptance.
  task automatic send_item(logic [31:0] t, logic [15:0] p, logic [15:0] y,
                           logic [31:0] cg, logic cgv);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    thrust <= t;
    pitch_command <= p;
    yaw_command <= y;
    cg_station <= cg;
    cg_valid <= cgv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every expected result has arrived and the pipeline is empty.
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(int n);
    logic [31:0] t;
    logic [15:0] p, y;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: t = $urandom;
        1: t = 32'h7FFF_FFFF - $urandom_range(3);
        2: t = $urandom_range(255, 0) | (i[0] ? 32'h8000_0000 : 32'h0);
        default: t = $urandom_range(32'h0FFF_FFFF, 0);
      endcase
      p = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(3000)) - 1500);
      y = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(3000)) - 1500);
      send_item(t, p, y, $urandom, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset configuration, extremes of thrust and angles.
    send_item(32'h0000_0100, 16'h0000, 16'h0000, 32'h0, 1'b0);
    send_item(32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 32'h8000_0000, 1'b1);
    send_item(32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 32'h7FFF_FFFF, 1'b1);
    send_item(32'h0000_0000, 16'h0100, 16'h0100, 32'h1234, 1'b1);
    send_item(32'h8000_0000, 16'h0100, 16'hFF00, 32'h1234, 1'b1);
    send_item(32'h0000_0001, 16'h0596, 16'hFA6A, 32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 16'h0000, 16'h0000, 32'h0, 1'b0);
    // The sender holds off here until every expected result has come.
    drain();
    write_reg(gtw_pkg::RegNozzle, 32'h8000_0000);
    write_reg(gtw_pkg::RegMaxAngle, 32'h1FFF);
    send_item(32'h7FFF_FFFF, 16'h1FFF, 16'hE001, 32'h7FFF_FFFF, 1'b1);
    send_item(32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 1'b0);
    send_item(32'h0001_0000, 16'h8000, 16'h0000, 32'h8000_0000, 1'b1);
    drain();
    write_reg(gtw_pkg::RegNozzle, 32'h7FFF_FFFF);
    write_reg(gtw_pkg::RegMaxAngle, 32'h0);
    send_item(32'h7FFF_FFFF, 16'h1FFF, 16'hE001, 32'h8000_0000, 1'b1);
    send_item(32'h0000_1000, 16'h0400, 16'h0400, 32'h0001_0000, 1'b1);
    drain();
    // Fixed axial mount: thrust passes straight through, negative too.
    write_reg(gtw_pkg::RegGimbal, 32'h0);
    send_item(32'h8000_0000, 16'h1000, 16'h1000, 32'h1, 1'b1);
    send_item(32'h7FFF_FFFF, 16'hF000, 16'h1000, 32'h1, 1'b0);
    send_item(32'h0000_0000, 16'h0000, 16'h0000, 32'h0, 1'b0);
    drain();
    write_reg(2'd3, 32'hFFFF_FFFF);   // unknown index, ignored

    // Random phases across several settings; the fourth one runs without idling.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(gtw_pkg::RegGimbal, (ph % 3 == 2) ? 32'h0 : 32'h1);
      write_reg(gtw_pkg::RegMaxAngle, (ph == 1) ? 32'h1FFF : $urandom_range(8191));
      write_reg(gtw_pkg::RegNozzle, $urandom);
      calm = (ph == 3);
      send_random(145);
    end
    calm = 1'b0;
    drain();

    if (failures == 0) begin
      $display("gimbal_thrust_wrench test passed");
    end else begin
      $display("gimbal_thrust_wrench test failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/gtw_pkg.sv
rtl/gtw_cordic_stage.sv
rtl/gtw_wrench.sv
rtl/gimbal_thrust_wrench.sv
dv/gtw_wrench_checker.sv
dv/tb_gimbal_thrust_wrench.sv
